// ===== hdl/mtp_pkg.sv =====
// Package: types, constants and the arctangent table of the move-to-pose controller
`timescale 1ns / 1ps
package mtp_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int ANG_W   = 16;
    localparam int DIST_W  = COORD_WIDTH + 1;
    // CORDIC datapath: difference (COORD_WIDTH+1) scaled by 256, with growth margin
    localparam int CW      = COORD_WIDTH + 1 + 8 + 3;
    localparam int ZW      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ORIENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL  = 3'd5;

    localparam logic [36:0] INV_GAIN_Q20 = 37'd636751;
    localparam logic [ZW-1:0] HALF_TURN  = 18'd32768;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [ANG_W-1:0]       heading;
        logic signed [COORD_WIDTH-1:0] goal_x;
        logic signed [COORD_WIDTH-1:0] goal_y;
        logic signed [ANG_W-1:0]       goal_heading;
    } t_pose;

    typedef struct packed {
        logic [DIST_W-1:0]       distance;
        logic signed [15:0]      lin_speed;
        logic signed [15:0]      ang_speed;
        logic                    reversing;
        logic                    arrived;
    } t_cmd;

    typedef struct packed {
        logic [15:0] gain_distance;
        logic [15:0] gain_heading;
        logic [15:0] gain_orientation;
        logic [14:0] max_linear;
        logic [14:0] max_angular;
        logic [11:0] arrive_tolerance;
    } t_cfg;

    function automatic logic [ZW-1:0] atan_entry(input int i);
        logic [ZW-1:0] t;
        case (i)
            0: t = 18'd8192;   1: t = 18'd4836;  2: t = 18'd2555;  3: t = 18'd1297;
            4: t = 18'd651;    5: t = 18'd326;   6: t = 18'd163;   7: t = 18'd81;
            8: t = 18'd41;     9: t = 18'd20;   10: t = 18'd10;   11: t = 18'd5;
            12: t = 18'd3;    13: t = 18'd1;    14: t = 18'd1;
            default: t = '0;
        endcase
        return t;
    endfunction
endpackage

// ===== hdl/mtp_stream_if.sv =====
// Interface: valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
interface mtp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mtp_cordic.sv =====
// Pipelined vectoring CORDIC with side-band pose and valid travelling alongside
`timescale 1ns / 1ps
module mtp_cordic (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [mtp_pkg::CW-1:0] i_x,
    input  logic signed [mtp_pkg::CW-1:0] i_y,
    input  logic [mtp_pkg::ZW-1:0]  i_z,
    input  logic [31:0]             i_side,
    output logic                    o_valid,
    output logic signed [mtp_pkg::CW-1:0] o_x,
    output logic [mtp_pkg::ZW-1:0]  o_z,
    output logic [31:0]             o_side
);
    import mtp_pkg::*;

    logic                 r_v    [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y    [CORDIC_STAGES+1];
    logic [ZW-1:0]        r_z    [CORDIC_STAGES+1];
    logic [31:0]          r_side [CORDIC_STAGES+1];

    // stage 0 is the entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0] <= i_x; r_y[0] <= i_y; r_z[0] <= i_z; r_side[0] <= i_side;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        logic signed [CW-1:0] xs, ys;
        assign xs = r_x[g] >>> g;
        assign ys = r_y[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                if (!r_y[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] + ys;
                    r_y[g+1] <= r_y[g] - xs;
                    r_z[g+1] <= r_z[g] + atan_entry(g);
                end else begin
                    r_x[g+1] <= r_x[g] - ys;
                    r_y[g+1] <= r_y[g] + xs;
                    r_z[g+1] <= r_z[g] - atan_entry(g);
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES];
    assign o_x     = r_x[CORDIC_STAGES];
    assign o_z     = r_z[CORDIC_STAGES];
    assign o_side  = r_side[CORDIC_STAGES];
endmodule

// ===== hdl/move_to_pose_control_step.sv =====
// Top level: polar move-to-pose controller, one pose per cycle unless the output stalls
//
// Input channel carries current pose and goal pose beats; output channel carries
// distance, linear and angular speed commands and reversing/arrived flags.
// Configuration is a plain write port: index 0..5 selects gain_distance,
// gain_heading, gain_orientation, max_linear, max_angular, arrive_tolerance.
// A beat passes CORDIC_STAGES + 6 registers: a difference stage, the CORDIC
// entry, one stage per micro-rotation, a gain-correction multiply, the speed
// multiplies, the saturation stage and the output register. Throughput is one
// beat per cycle while the receiver takes beats; the pipeline is a single
// chain clocked by a shared enable, so the rate drops only on a receiver stall.
// When the receiver stalls with the output register full, the whole pipeline
// holds and input ready drops; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the register
// reset values; payload registers are not reset.
`timescale 1ns / 1ps
module move_to_pose_control_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mtp_stream_if.sink                       s_in,
    mtp_stream_if.source                     m_out,
    input  logic                             i_cfg_we,
    input  logic [mtp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mtp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mtp_pkg::*;

    t_cfg  r_cfg;
    logic  en;
    t_pose pin;
    assign pin = s_in.data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_distance    <= 16'd246;
            r_cfg.gain_heading     <= 16'd1638;
            r_cfg.gain_orientation <= 16'd3686;
            r_cfg.max_linear       <= 15'd328;
            r_cfg.max_angular      <= 15'd2608;
            r_cfg.arrive_tolerance <= 12'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_DIST:   r_cfg.gain_distance    <= i_cfg_data;
                REG_GAIN_HEAD:   r_cfg.gain_heading     <= i_cfg_data;
                REG_GAIN_ORIENT: r_cfg.gain_orientation <= i_cfg_data;
                REG_MAX_LIN:     r_cfg.max_linear       <= i_cfg_data[14:0];
                REG_MAX_ANG:     r_cfg.max_angular      <= i_cfg_data[14:0];
                REG_ARRIVE_TOL:  r_cfg.arrive_tolerance <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // stall: everything advances unless the output holds an untaken beat
    logic r_ov;
    assign en = !r_ov || m_out.ready;
    assign s_in.ready = en;

    // stage A: differences
    logic r_av;
    logic signed [COORD_WIDTH:0] r_dx, r_dy;
    logic [15:0] r_ath, r_athg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (en) r_av <= s_in.valid;
        if (en) begin
            r_dx <= {pin.goal_x[COORD_WIDTH-1], pin.goal_x}
                  - {pin.pos_x[COORD_WIDTH-1], pin.pos_x};
            r_dy <= {pin.goal_y[COORD_WIDTH-1], pin.goal_y}
                  - {pin.pos_y[COORD_WIDTH-1], pin.pos_y};
            r_ath  <= pin.heading;
            r_athg <= pin.goal_heading;
        end
    end

    // CORDIC pre-rotation by a half turn when dx is negative
    logic signed [CW-1:0] cx, cy, sx, sy;
    logic zero_d;
    assign sx = {{(CW-COORD_WIDTH-9){r_dx[COORD_WIDTH]}}, r_dx, 8'd0};
    assign sy = {{(CW-COORD_WIDTH-9){r_dy[COORD_WIDTH]}}, r_dy, 8'd0};
    assign cx = r_dx[COORD_WIDTH] ? -sx : sx;
    assign cy = r_dx[COORD_WIDTH] ? -sy : sy;
    assign zero_d = (r_dx == '0) && (r_dy == '0);

    logic c_v;
    logic signed [CW-1:0] c_x;
    logic [ZW-1:0] c_z;
    logic [31:0] c_side;
    logic [31:0] side_in;
    assign side_in = {r_ath, r_athg};

    mtp_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_av),
        .i_x(cx), .i_y(cy), .i_z(r_dx[COORD_WIDTH] ? HALF_TURN : '0),
        .i_side(side_in), .o_valid(c_v), .o_x(c_x), .o_z(c_z), .o_side(c_side)
    );

    // zero-difference flag rides alongside the CORDIC
    logic r_zq [CORDIC_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zq[0] <= zero_d;
            for (int k = 0; k < CORDIC_STAGES; k++) r_zq[k+1] <= r_zq[k];
        end
    end

    // stage B: gain correction multiply, angle errors
    logic r_bv, r_bzero;
    logic [CW+20-1:0] r_bprod;
    logic [15:0] r_bbear, r_bth, r_bthg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (en) r_bv <= c_v;
        if (en) begin
            r_bprod <= (CW+20)'(c_x[CW-2:0]) * (CW+20)'(INV_GAIN_Q20[19:0]);
            r_bzero <= r_zq[CORDIC_STAGES] || c_x[CW-1];
            r_bbear <= r_zq[CORDIC_STAGES] ? 16'd0 : c_z[15:0];
            r_bth   <= c_side[31:16];
            r_bthg  <= c_side[15:0];
        end
    end

    // distance rounding and saturation
    logic [CW+20-1:0] rnd;
    logic [CW+20-29:0] dq;
    logic [DIST_W-1:0] dist_b;
    assign rnd = r_bprod + (CW+20)'(1 << 27);
    assign dq  = rnd[CW+20-1:28];
    assign dist_b = r_bzero ? '0 :
                    ((dq >> DIST_W) != '0) ? {DIST_W{1'b1}} : dq[DIST_W-1:0];
    logic signed [15:0] alpha_b, beta_b;
    assign alpha_b = r_bbear - r_bth;
    assign beta_b  = r_bthg - r_bth - alpha_b;

    // stage C: speed products
    logic r_cv, r_crev, r_carr;
    logic [DIST_W-1:0] r_cdist;
    logic [DIST_W+16-1:0] r_cvp;
    logic signed [33:0] r_cwp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (en) r_cv <= r_bv;
        if (en) begin
            r_cdist <= dist_b;
            r_cvp   <= (DIST_W+16)'(dist_b) * (DIST_W+16)'(r_cfg.gain_distance);
            r_cwp   <= $signed({1'b0, r_cfg.gain_heading}) * alpha_b
                     - $signed({1'b0, r_cfg.gain_orientation}) * beta_b;
            r_crev  <= (alpha_b > 16'sd16384) || (alpha_b < -16'sd16384);
            r_carr  <= dist_b <= DIST_W'(r_cfg.arrive_tolerance);
        end
    end

    // round and sign
    logic signed [DIST_W+16:0] v_s;
    logic signed [34:0] w_s;
    assign v_s = $signed({1'b0, (r_cvp + (DIST_W+16)'(2048)) >> 12});
    assign w_s = (35'(r_cwp) + 35'sd2048) >>> 12;

    // stage D: saturation
    logic r_dv, r_drev, r_darr;
    logic [DIST_W-1:0] r_ddist;
    logic signed [15:0] r_dlin, r_dang;
    logic signed [DIST_W+16:0] v_n, lim_v;
    logic signed [34:0] lim_w;
    assign v_n   = r_crev ? -v_s : v_s;
    assign lim_v = (DIST_W+17)'(r_cfg.max_linear);
    assign lim_w = 35'(r_cfg.max_angular);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (en) r_dv <= r_cv;
        if (en) begin
            r_ddist <= r_cdist; r_drev <= r_crev; r_darr <= r_carr;
            r_dlin <= (v_n > lim_v) ? 16'(lim_v) : (v_n < -lim_v) ? -16'(lim_v) : 16'(v_n);
            r_dang <= (w_s > lim_w) ? 16'(lim_w) : (w_s < -lim_w) ? -16'(lim_w) : 16'(w_s);
        end
    end

    // output register
    t_cmd r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r_dv;
        if (en) r_out <= '{r_ddist, r_dlin, r_dang, r_drev, r_darr};
    end
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;

    // a stalled output beat holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_out.ready |=> r_ov && $stable(r_out)) else $error("out beat changed");
    // linear speed never exceeds its limit
    a_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.lin_speed <= $signed({1'b0, r_cfg.max_linear}))
              && (r_out.lin_speed >= -$signed({1'b0, r_cfg.max_linear})))
        else $error("lin_speed over limit");
    // arrival implies small distance
    a_arr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.arrived |-> r_out.distance <= DIST_W'(4095))
        else $error("arrived with large distance");
    // ready follows stall state
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> s_in.ready) else $error("ready low while empty");
endmodule
